// ----- hw/rtl/tga_rle_pixel_decoder_macros.svh -----
// Assertion macros shared by the TGA RLE decoder modules.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication.
`define TGARLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tgarle_pkg.sv -----
// Package for the TGA RLE pixel decoder: types, constants and codes.
// No dependencies; used by every module of the block.
`default_nettype none

package tgarle_pkg;

  localparam int MaxPixelBytes = 16;
  localparam int PixelW        = MaxPixelBytes * 8;
  localparam int ByteCntW      = $clog2(MaxPixelBytes);
  localparam int QDepth        = 4;
  localparam int QPtrW         = $clog2(QDepth);

  // Register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BYTES  = 3'd2;
  localparam logic [2:0] REG_CORNER = 3'd3;

  // Origin corners
  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TL = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  localparam logic [7:0] RepeatBase = 8'd128;
  localparam logic [7:0] RepeatBias = 8'd127;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_RAW,
    MODE_REPEAT
  } mode_t;

  typedef enum logic {
    CMD_WRITE,
    CMD_FAIL
  } cmd_kind_t;

  // One queued job for the back end: a pixel written count times, or a fail.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          count;
    logic [PixelW-1:0]   pixel;
  } cmd_t;

  // Effective configuration and derived walk values.
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [4:0]  bytes;
    logic [31:0] frame_total;
    logic [31:0] start_index;
    logic [31:0] unit_delta;
    logic [31:0] wrap_delta;
    logic        rearm;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tgarle_cfg.sv -----
// Configuration registers and derived walk constants (area, start, deltas).
// Depends on tgarle_pkg.
`default_nettype none

module tgarle_cfg
  import tgarle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [4:0]  pixel_bytes;
  logic [1:0]  corner_sel;
  logic [31:0] area;
  logic [31:0] start_index;
  logic [31:0] wrap_delta;

  logic [15:0] eff_w;
  logic [15:0] eff_h;
  logic [4:0]  eff_bytes;
  logic [31:0] area_next;
  logic [31:0] w32;
  logic [31:0] two_w;
  logic [31:0] start_index_next;
  logic [31:0] wrap_delta_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 16'd1;
      image_height  <= 16'd1;
      pixel_bytes   <= 5'd4;
      corner_sel    <= CORNER_TL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data;
        REG_HEIGHT: image_height  <= cfg_data;
        REG_BYTES:  pixel_bytes   <= cfg_data[4:0];
        REG_CORNER: corner_sel    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = (image_width == 16'd0) ? 16'd1 : image_width;
    eff_h = (image_height == 16'd0) ? 16'd1 : image_height;
    if (pixel_bytes == 5'd0) begin
      eff_bytes = 5'd1;
    end else if (pixel_bytes > 5'(MaxPixelBytes)) begin
      eff_bytes = 5'(MaxPixelBytes);
    end else begin
      eff_bytes = pixel_bytes;
    end
    area_next = {16'd0, eff_w} * {16'd0, eff_h};
    w32       = {16'd0, eff_w};
    two_w     = {15'd0, eff_w, 1'b0};
    unique case (corner_sel)
      CORNER_BL: begin
        start_index_next = area - w32;
        wrap_delta_next  = 32'd1 - two_w;
      end
      CORNER_BR: begin
        start_index_next = area - 32'd1;
        wrap_delta_next  = '1;
      end
      CORNER_TL: begin
        start_index_next = 32'd0;
        wrap_delta_next  = 32'd1;
      end
      default: begin
        start_index_next = w32 - 32'd1;
        wrap_delta_next  = two_w - 32'd1;
      end
    endcase
  end

  // area and wrap delta are registered from the config registers, start from area
  always_ff @(posedge clk) begin
    if (rst) begin
      area        <= 32'd1;
      start_index <= 32'd0;
      wrap_delta  <= 32'd1;
    end else begin
      area        <= area_next;
      start_index <= start_index_next;
      wrap_delta  <= wrap_delta_next;
    end
  end

  always_comb begin
    cfg.width       = eff_w;
    cfg.height      = eff_h;
    cfg.bytes       = eff_bytes;
    cfg.frame_total = area;
    cfg.start_index = start_index;
    cfg.unit_delta  = corner_sel[0] ? '1 : 32'd1;
    cfg.wrap_delta  = wrap_delta;
    cfg.rearm       = cfg_we && (cfg_index <= REG_CORNER);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tgarle_front.sv -----
// Front end: takes stream bytes, parses packet headers, assembles pixels
// and pushes write or fail jobs. Depends on tgarle_pkg.
`default_nettype none

module tgarle_front
  import tgarle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  cfg_t            cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data,
  input  wire logic       in_end,
  input  wire logic       full,
  output logic            push,
  output cmd_t            push_cmd
);

  mode_t                mode;
  mode_t                mode_next;
  logic [7:0]           pkt_left;
  logic [7:0]           pkt_left_next;
  logic [ByteCntW-1:0]  byte_cnt;
  logic [ByteCntW-1:0]  byte_cnt_next;
  logic [PixelW-1:0]    pixbuf;
  logic [PixelW-1:0]    pixbuf_next;
  logic [31:0]          pixels_done;
  logic [31:0]          pixels_done_next;

  logic                 accept;
  logic [PixelW-1:0]    pix_new;
  logic                 pix_done;
  logic [7:0]           write_cnt;
  logic [32:0]          done_sum;
  logic                 frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HEADER;
      pkt_left    <= 8'd0;
      byte_cnt    <= '0;
      pixbuf      <= '0;
      pixels_done <= 32'd0;
    end else begin
      mode        <= mode_next;
      pkt_left    <= pkt_left_next;
      byte_cnt    <= byte_cnt_next;
      pixbuf      <= pixbuf_next;
      pixels_done <= pixels_done_next;
    end
  end

  always_comb begin
    in_ready  = !full;
    accept    = in_valid && !full;
    pix_new   = (byte_cnt == '0) ? '0 : pixbuf;
    pix_new[{byte_cnt, 3'b000} +: 8] = in_data;
    pix_done  = ({1'b0, byte_cnt} + 5'd1) >= cfg.bytes;
    write_cnt = (mode == MODE_RAW) ? 8'd1 : pkt_left;
    done_sum  = {1'b0, pixels_done} + {25'd0, write_cnt};
    frame_end = done_sum >= {1'b0, cfg.frame_total};

    mode_next        = mode;
    pkt_left_next    = pkt_left;
    byte_cnt_next    = byte_cnt;
    pixbuf_next      = pixbuf;
    pixels_done_next = pixels_done;
    push             = 1'b0;
    push_cmd.kind    = CMD_WRITE;
    push_cmd.count   = write_cnt;
    push_cmd.pixel   = pix_new;

    if (cfg.rearm) begin
      mode_next        = MODE_HEADER;
      pkt_left_next    = 8'd0;
      byte_cnt_next    = '0;
      pixbuf_next      = '0;
      pixels_done_next = 32'd0;
    end else if (accept) begin
      if (in_end) begin
        push             = 1'b1;
        push_cmd.kind    = CMD_FAIL;
        push_cmd.count   = 8'd0;
        push_cmd.pixel   = '0;
        mode_next        = MODE_HEADER;
        pkt_left_next    = 8'd0;
        byte_cnt_next    = '0;
        pixbuf_next      = '0;
        pixels_done_next = 32'd0;
      end else begin
        unique case (mode)
          MODE_HEADER: begin
            byte_cnt_next = '0;
            if (in_data < RepeatBase) begin
              mode_next     = MODE_RAW;
              pkt_left_next = in_data + 8'd1;
            end else begin
              mode_next     = MODE_REPEAT;
              pkt_left_next = in_data - RepeatBias;
            end
          end
          MODE_RAW, MODE_REPEAT: begin
            pixbuf_next = pix_new;
            if (!pix_done) begin
              byte_cnt_next = byte_cnt + 1'b1;
            end else begin
              byte_cnt_next = '0;
              push          = 1'b1;
              if (frame_end) begin
                // last pixel of the image: rest of the packet is dropped
                mode_next        = MODE_HEADER;
                pkt_left_next    = 8'd0;
                pixels_done_next = 32'd0;
              end else begin
                pixels_done_next = done_sum[31:0];
                if (mode == MODE_REPEAT) begin
                  mode_next     = MODE_HEADER;
                  pkt_left_next = 8'd0;
                end else begin
                  pkt_left_next = pkt_left - 8'd1;
                  if (pkt_left == 8'd1) begin
                    mode_next = MODE_HEADER;
                  end
                end
              end
            end
          end
          default: mode_next = MODE_HEADER;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tgarle_queue.sv -----
// Short job queue between the front and back ends, register based.
// Depends on tgarle_pkg and the shared assertion macros.
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module tgarle_queue
  import tgarle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   fill;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_comb begin
    head  = entries[rd_ptr];
    full  = (fill == (QPtrW+1)'(QDepth));
    empty = (fill == '0);
  end

  `TGARLE_ASSERT_IMPL(a_no_overflow, push, !full, "queue push while full")
  `TGARLE_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue pop while empty")
  `TGARLE_ASSERT_NEXT(a_push_lands, push && !pop, !empty, "pushed job missing")

endmodule

`default_nettype wire

// ----- hw/rtl/tgarle_back.sv -----
// Back end: runs queued jobs through the pixel walk, up to two writes a beat,
// into an output register. Depends on tgarle_pkg and the assertion macros.
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module tgarle_back
  import tgarle_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  cfg_t              cfg,
  input  cmd_t              head,
  input  wire logic         empty,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              status,
  output logic [31:0]       first_index,
  output logic [31:0]       second_index,
  output logic              second_valid,
  output logic [PixelW-1:0] pixel,
  output logic              frame_done,
  output logic              last_result
);

  cmd_t        cur;
  logic        cur_valid;
  logic [7:0]  left;
  logic        fresh;
  logic [31:0] widx;
  logic [15:0] line_left;
  logic [15:0] lines_left;

  logic        load_ok;
  logic        exec;
  logic        is_fail;
  logic [31:0] idx0, idx1, idx2;
  logic [15:0] lpl0, lpl1, lpl2;
  logic [15:0] ll0, ll1, ll2;
  logic [15:0] lpl_dec1, lpl_dec2;
  logic        wrap1, wrap2;
  logic        done1, done2;
  logic        pair;
  logic        done;
  logic [7:0]  left_next;
  logic        fin;

  always_comb begin
    load_ok = !out_valid || out_ready;
    exec    = cur_valid && load_ok;
    is_fail = (cur.kind == CMD_FAIL);

    idx0 = fresh ? cfg.start_index : widx;
    lpl0 = fresh ? cfg.width : line_left;
    ll0  = fresh ? cfg.height : lines_left;

    lpl_dec1 = lpl0 - 16'd1;
    wrap1    = (lpl_dec1 == 16'd0);
    ll1      = wrap1 ? ll0 - 16'd1 : ll0;
    done1    = wrap1 && (ll1 == 16'd0);
    idx1     = idx0 + (wrap1 ? cfg.wrap_delta : cfg.unit_delta);
    lpl1     = wrap1 ? cfg.width : lpl_dec1;

    lpl_dec2 = lpl1 - 16'd1;
    wrap2    = (lpl_dec2 == 16'd0);
    ll2      = wrap2 ? ll1 - 16'd1 : ll1;
    done2    = wrap2 && (ll2 == 16'd0);
    idx2     = idx1 + (wrap2 ? cfg.wrap_delta : cfg.unit_delta);
    lpl2     = wrap2 ? cfg.width : lpl_dec2;

    pair      = !is_fail && !done1 && (left > 8'd1);
    done      = done1 || (pair && done2);
    left_next = left - (pair ? 8'd2 : 8'd1);
    fin       = is_fail || done || (left_next == 8'd0);

    pop = !empty && (!cur_valid || (exec && fin));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      fresh     <= 1'b1;
    end else begin
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.rearm) begin
        fresh <= 1'b1;
      end else if (exec) begin
        if (is_fail || done) begin
          fresh <= 1'b1;
        end else begin
          fresh <= 1'b0;
        end
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (exec && fin) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (exec) begin
      if (is_fail) begin
        status       <= 1'b1;
        first_index  <= 32'd0;
        second_index <= 32'd0;
        second_valid <= 1'b0;
        pixel        <= '0;
        frame_done   <= 1'b0;
        last_result  <= 1'b1;
      end else begin
        status       <= 1'b0;
        first_index  <= idx0;
        second_index <= pair ? idx1 : 32'd0;
        second_valid <= pair;
        pixel        <= cur.pixel;
        frame_done   <= done;
        last_result  <= fin;
        widx         <= pair ? idx2 : idx1;
        line_left    <= pair ? lpl2 : lpl1;
        lines_left   <= pair ? ll2 : ll1;
      end
    end
    if (pop) begin
      cur  <= head;
      left <= head.count;
    end else if (exec) begin
      left <= left_next;
    end
  end

  `TGARLE_ASSERT_IMPL(a_done_ends_item, out_valid && frame_done, last_result,
                      "frame end not on the item's final beat")
  `TGARLE_ASSERT_IMPL(a_job_has_work, cur_valid && (cur.kind == CMD_WRITE), left != 8'd0,
                      "write job with no writes left")

endmodule

`default_nettype wire

// ----- hw/rtl/tga_rle_pixel_decoder.sv -----
// Top level of the TGA RLE pixel decoder: config, front end, job queue, back end.
// Depends on tgarle_pkg, tgarle_cfg, tgarle_front, tgarle_queue, tgarle_back.
//
//   channel   group                     beat
//   input     s_axis_*                  one stream byte, or end of stream
//   output    m_axis_*                  one write of one or two pixels, or a fail
//   config    cfg_we/cfg_index/cfg_data one register write
//
// Input takes one byte per cycle while the 4-entry job queue has room.
// A raw pixel gives one output beat; a repeat of n gives ceil(n/2) beats, one
// per cycle from the back end while m_axis_tready is high; the back end sets
// the rate on long repeats. A job passes through the job queue and the back
// end's current-job register before the output register. Reset is synchronous;
// no clearing pass. Derived walk values are registered from the config registers.
`default_nettype none

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] stream_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] first_index, [63:32] second_index, [64] second_valid,
  // [128:65] pixel_low, [192:129] pixel_high, [193] frame_done, [199:194] zero
  output logic [199:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // [0] status
  output logic              m_axis_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  cfg_t              cfg;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  cmd_t              head;
  logic              full;
  logic              empty;
  logic [31:0]       first_index;
  logic [31:0]       second_index;
  logic              second_valid;
  logic [PixelW-1:0] pixel;
  logic              frame_done;

  tgarle_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgarle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_end   (s_axis_tuser),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tgarle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  tgarle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .status       (m_axis_tuser),
    .first_index  (first_index),
    .second_index (second_index),
    .second_valid (second_valid),
    .pixel        (pixel),
    .frame_done   (frame_done),
    .last_result  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, frame_done, pixel[127:64], pixel[63:0], second_valid,
                         second_index, first_index};

endmodule

`default_nettype wire
